// ===== design/bfm_pkg.sv =====
// Shared types and constants of the beacon frame matcher.
// Used by every module of the block; depends on nothing.
package bfm_pkg;

  // Input event kinds
  localparam logic REQ_SAMPLE   = 1'b0;
  localparam logic REQ_WATCHDOG = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_ONE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_TWO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_THREE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LEVEL    = 3'd4;

  localparam int unsigned PATTERN_W = 16;
  localparam int unsigned SENSOR_W  = 4;
  localparam int unsigned COUNT_W   = 5;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

  // Per-sensor receiver phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_DATA = 3'b010,
    PH_STOP = 3'b100
  } phase_t;

  // Kind of the next wait reported with each result
  typedef enum logic [1:0] {
    WAIT_POLL  = 2'd0,
    WAIT_BIT   = 2'd1,
    WAIT_QUIET = 2'd2,
    WAIT_WDOG  = 2'd3
  } wait_t;

  typedef struct packed {
    logic [PATTERN_W-1:0] pattern_one;
    logic [PATTERN_W-1:0] pattern_two;
    logic [PATTERN_W-1:0] pattern_three;
    logic                 start_level;
    logic                 stop_level;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [COUNT_W-1:0] bit_count;
    logic [2:0]         cand;
    logic [2:0]         flags;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{
    phase:     PH_IDLE,
    bit_count: '0,
    cand:      '0,
    flags:     '0
  };

endpackage

// ===== design/bfm_cfg_regs.sv =====
// Configuration registers of the beacon frame matcher.
// Depends on bfm_pkg for the register indexes and the cfg_t bundle.
module bfm_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [bfm_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [bfm_pkg::PATTERN_W-1:0]  wr_data,
  output bfm_pkg::cfg_t                  cfg
);

  bfm_pkg::cfg_t cfg_r;
  bfm_pkg::cfg_t cfg_nxt;

  // Decode the register index of a write transfer
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        bfm_pkg::REG_PATTERN_ONE:   cfg_nxt.pattern_one   = wr_data;
        bfm_pkg::REG_PATTERN_TWO:   cfg_nxt.pattern_two   = wr_data;
        bfm_pkg::REG_PATTERN_THREE: cfg_nxt.pattern_three = wr_data;
        bfm_pkg::REG_START_LEVEL:   cfg_nxt.start_level   = wr_data[0];
        bfm_pkg::REG_STOP_LEVEL:    cfg_nxt.stop_level    = wr_data[0];
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_one   <= '0;
      cfg_r.pattern_two   <= '0;
      cfg_r.pattern_three <= '0;
      cfg_r.start_level   <= 1'b1;
      cfg_r.stop_level    <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== design/bfm_state_file.sv =====
// Per-sensor receiver state held in flip-flops, one entry per sensor.
// Depends on bfm_pkg for entry_t and its reset value.
module bfm_state_file #(
  parameter int SENSOR_COUNT = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [bfm_pkg::SENSOR_W-1:0]  sensor,
  input  logic                          wr_en,
  input  bfm_pkg::entry_t               wr_entry,
  output bfm_pkg::entry_t               rd_entry,
  output logic                          in_range
);

  bfm_pkg::entry_t entry_r [SENSOR_COUNT];

  // Compare against the sensor count with one spare bit so that sixteen fits
  assign in_range = {1'b0, sensor} < (bfm_pkg::SENSOR_W + 1)'(SENSOR_COUNT);

  // Select the addressed entry
  always_comb begin
    rd_entry = bfm_pkg::ENTRY_RESET;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      if (sensor == bfm_pkg::SENSOR_W'(i)) begin
        rd_entry = entry_r[i];
      end
    end
  end

  // Write back the updated entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        entry_r[i] <= bfm_pkg::ENTRY_RESET;
      end
    end else begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        if (wr_en && sensor == bfm_pkg::SENSOR_W'(i)) begin
          entry_r[i] <= wr_entry;
        end
      end
    end
  end

endmodule

// ===== design/bfm_update.sv =====
// Next-state and result logic of one sensor receiver for one event.
// Purely combinational; depends on bfm_pkg for cfg_t, entry_t and codes.
module bfm_update #(
  parameter int FRAME_BITS = 8
) (
  input  logic             req_type,
  input  logic             sample,
  input  logic             in_range,
  input  bfm_pkg::cfg_t    cfg,
  input  bfm_pkg::entry_t  cur,
  output bfm_pkg::entry_t  nxt,
  output logic             wr_en,
  output logic [2:0]       flags,
  output bfm_pkg::wait_t   wait_kind,
  output logic             restart
);

  localparam logic [bfm_pkg::COUNT_W-1:0] FRAME_LIM = bfm_pkg::COUNT_W'(FRAME_BITS);

  logic [bfm_pkg::COUNT_W-1:0] cnt_inc;
  logic [bfm_pkg::COUNT_W-1:0] cnt_prev;
  logic [3:0]                  bit_idx;
  logic [2:0]                  want;
  logic [2:0]                  miss;
  logic [2:0]                  cand_keep;
  bfm_pkg::entry_t             upd;
  bfm_pkg::wait_t              upd_wait;
  logic                        upd_restart;

  // Saturating bit count and the expected bit of each pattern
  always_comb begin
    cnt_inc   = (cur.bit_count == bfm_pkg::COUNT_MAX) ? cur.bit_count
                                                      : cur.bit_count + 5'd1;
    cnt_prev  = cnt_inc - 5'd1;
    bit_idx   = cnt_prev[3:0];
    want      = {cfg.pattern_three[bit_idx], cfg.pattern_two[bit_idx],
                 cfg.pattern_one[bit_idx]};
    miss      = want ^ {3{sample}};
    cand_keep = cur.cand & ~miss;
  end

  // Advance the receiver of the addressed sensor
  always_comb begin
    upd         = cur;
    upd_wait    = bfm_pkg::WAIT_POLL;
    upd_restart = 1'b0;
    if (req_type == bfm_pkg::REQ_WATCHDOG) begin
      upd.flags   = 3'b000;
      upd_wait    = bfm_pkg::WAIT_WDOG;
      upd_restart = 1'b1;
    end else begin
      unique case (cur.phase)
        bfm_pkg::PH_DATA: begin
          upd.bit_count = cnt_inc;
          upd.cand      = cand_keep;
          upd.flags     = cur.flags & ~miss;
          if (cand_keep != 3'b000) begin
            upd_wait    = bfm_pkg::WAIT_BIT;
            upd_restart = 1'b1;
            upd.phase   = (cnt_inc < FRAME_LIM) ? bfm_pkg::PH_DATA : bfm_pkg::PH_STOP;
          end else begin
            upd.phase = bfm_pkg::PH_IDLE;
            upd_wait  = bfm_pkg::WAIT_QUIET;
          end
        end
        bfm_pkg::PH_STOP: begin
          upd.bit_count = cnt_inc;
          upd.phase     = bfm_pkg::PH_IDLE;
          if (sample == cfg.stop_level) begin
            upd.flags   = cur.cand;
            upd_restart = 1'b1;
          end else begin
            upd.flags = 3'b000;
            upd_wait  = bfm_pkg::WAIT_QUIET;
          end
        end
        default: begin
          // start search
          upd.phase = bfm_pkg::PH_IDLE;
          if (sample == cfg.start_level) begin
            upd.cand      = 3'b111;
            upd.bit_count = '0;
            upd.phase     = bfm_pkg::PH_DATA;
            upd_wait      = bfm_pkg::WAIT_BIT;
            upd_restart   = 1'b1;
          end
        end
      endcase
    end
  end

  // Leave sensors beyond the configured count untouched and report them empty
  assign nxt       = upd;
  assign wr_en     = in_range;
  assign flags     = in_range ? upd.flags : 3'b000;
  assign wait_kind = in_range ? upd_wait : bfm_pkg::WAIT_POLL;
  assign restart   = in_range & upd_restart;

endmodule

// ===== design/beacon_frame_matcher.sv =====
// Top level of the beacon frame matcher: input register, per-sensor state,
// update logic and result register. Depends on bfm_pkg, bfm_cfg_regs,
// bfm_state_file and bfm_update.
//
// Usage:
//   Each input transfer (in_valid high, in_stall low) brings one event for
//   one sensor: a bit sample or a watchdog expiry. Every event yields exactly
//   one result on the out_ channel with the sensor's match flags after the
//   update, the kind of the next wait and the watchdog restart mark.
//   Configuration is written through cfg_valid/cfg_index/cfg_data; cfg_ready
//   is always high. Write it only while no event is in flight.
// Flow and throughput:
//   An accepted event sits in the input register, is processed by one
//   read-modify-write of its sensor entry and moves into the result
//   register once that register is free; out_valid is high from then on. One
//   event per cycle is sustained while out_stall is low, also for back-to-back
//   events on the same sensor, as each entry is written back before the next read.
// Reset:
//   rst_n low puts all sensors in start search with flags cleared, patterns
//   zero, start level one and stop level zero; both channels empty.
// Stall:
//   While out_stall holds a result, the input register still takes one more
//   event; after that in_stall rises until the result is transferred.
module beacon_frame_matcher #(
  parameter int FRAME_BITS   = 8,
  parameter int SENSOR_COUNT = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input events
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_req_type,
  input  logic [bfm_pkg::SENSOR_W-1:0]   in_sensor_id,
  input  logic                           in_sample,
  // results
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bfm_pkg::SENSOR_W-1:0]   out_sensor,
  output logic                           out_match_one,
  output logic                           out_match_two,
  output logic                           out_match_three,
  output logic [1:0]                     out_next_wait,
  output logic                           out_watchdog_restart,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bfm_pkg::PATTERN_W-1:0]  cfg_data
);

  bfm_pkg::cfg_t                cfg;
  bfm_pkg::entry_t              cur_entry;
  bfm_pkg::entry_t              new_entry;
  logic                         in_range;
  logic                         upd_wr_en;
  logic [2:0]                   upd_flags;
  bfm_pkg::wait_t               upd_wait;
  logic                         upd_restart;

  logic                         in_accept;
  logic                         res_adv;
  logic                         s1_move;

  logic                         s1_valid_r;
  logic                         s1_valid_nxt;
  logic                         s1_req_type_r;
  logic [bfm_pkg::SENSOR_W-1:0] s1_sensor_r;
  logic                         s1_sample_r;

  logic                         out_valid_r;
  logic                         out_valid_nxt;
  logic [bfm_pkg::SENSOR_W-1:0] out_sensor_r;
  logic [2:0]                   out_flags_r;
  bfm_pkg::wait_t               out_wait_r;
  logic                         out_restart_r;

  // Handshake: result register frees when empty or transferred
  assign res_adv   = !out_valid_r || !out_stall;
  assign s1_move   = s1_valid_r && res_adv;
  assign in_stall  = s1_valid_r && !res_adv;
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  bfm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  bfm_state_file #(
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_state (
    .clk      (clk),
    .rst_n    (rst_n),
    .sensor   (s1_sensor_r),
    .wr_en    (s1_move && upd_wr_en),
    .wr_entry (new_entry),
    .rd_entry (cur_entry),
    .in_range (in_range)
  );

  bfm_update #(
    .FRAME_BITS (FRAME_BITS)
  ) u_update (
    .req_type  (s1_req_type_r),
    .sample    (s1_sample_r),
    .in_range  (in_range),
    .cfg       (cfg),
    .cur       (cur_entry),
    .nxt       (new_entry),
    .wr_en     (upd_wr_en),
    .flags     (upd_flags),
    .wait_kind (upd_wait),
    .restart   (upd_restart)
  );

  // Input register: fill on transfer, drain into the result register
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_req_type_r <= in_req_type;
      s1_sensor_r   <= in_sensor_id;
      s1_sample_r   <= in_sample;
    end
  end

  // Result register: hold while stalled
  assign out_valid_nxt = res_adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_sensor_r  <= s1_sensor_r;
      out_flags_r   <= upd_flags;
      out_wait_r    <= upd_wait;
      out_restart_r <= upd_restart;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_sensor           = out_sensor_r;
  assign out_match_one        = out_flags_r[0];
  assign out_match_two        = out_flags_r[1];
  assign out_match_three      = out_flags_r[2];
  assign out_next_wait        = out_wait_r;
  assign out_watchdog_restart = out_restart_r;

endmodule

// ===== design/bfm_checker.sv =====
// Port-level checks of the beacon frame matcher, bound to the top level.
// Depends on bfm_pkg for the wait codes.
module bfm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [bfm_pkg::SENSOR_W-1:0]  out_sensor,
  input logic                          out_match_one,
  input logic                          out_match_two,
  input logic                          out_match_three,
  input logic [1:0]                    out_next_wait,
  input logic                          out_watchdog_restart
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sensor)
      && $stable(out_next_wait))
    else $error("stalled result changed");

  // Stall the input only behind a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

  // Watchdog results restart the timer and clear all flags
  a_wdog: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_next_wait == bfm_pkg::WAIT_WDOG |->
      out_watchdog_restart && !out_match_one && !out_match_two && !out_match_three)
    else $error("watchdog result malformed");

  // Abandoned frames leave no flags and no restart
  a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_next_wait == bfm_pkg::WAIT_QUIET |->
      !out_watchdog_restart && !out_match_one && !out_match_two && !out_match_three)
    else $error("quiet result malformed");

endmodule

bind beacon_frame_matcher bfm_checker u_bfm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_sensor           (out_sensor),
  .out_match_one        (out_match_one),
  .out_match_two        (out_match_two),
  .out_match_three      (out_match_three),
  .out_next_wait        (out_next_wait),
  .out_watchdog_restart (out_watchdog_restart)
);

// ===== verif/beacon_frame_checker.sv =====
// Checker for the beacon frame matcher: watches the event, result and register
// channels, predicts every result from its own per-sensor receiver state and
// compares field by field. Depends on bfm_pkg.
module beacon_frame_checker
  import bfm_pkg::*;
#(
  parameter int FRAME_BITS   = 8,
  parameter int SENSOR_COUNT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // event channel
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_req_type,
  input  logic [SENSOR_W-1:0]  in_sensor_id,
  input  logic                 in_sample,
  // result channel
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [SENSOR_W-1:0]  out_sensor,
  input  logic                 out_match_one,
  input  logic                 out_match_two,
  input  logic                 out_match_three,
  input  logic [1:0]           out_next_wait,
  input  logic                 out_watchdog_restart,
  // register writes
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [PATTERN_W-1:0] cfg_data,
  // status for the testbench top
  output int                   error_count,
  output int                   reports_pending,
  output int                   reports_checked,
  output int                   frames_committed,
  output int                   frames_dropped
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor;
    logic [2:0]          flags;
    wait_t               next_wait;
    logic                restart;
  } beacon_report_t;

  localparam cfg_t CFG_RESET = '{
    pattern_one:   '0,
    pattern_two:   '0,
    pattern_three: '0,
    start_level:   1'b1,
    stop_level:    1'b0
  };

  cfg_t           shadow_cfg;
  entry_t         sensor_state [SENSOR_COUNT];
  beacon_report_t reports_due [$];
  beacon_report_t due;

  initial begin
    error_count      = 0;
    reports_pending  = 0;
    reports_checked  = 0;
    frames_committed = 0;
    frames_dropped   = 0;
  end

  task automatic report_error(input string msg);
    $display("[%0t] ERROR: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [3:0] got,
                             input logic [3:0] want);
    if (got !== want) begin
      report_error($sformatf("sensor %0d %s: got %0d, expected %0d",
                             due.sensor, name, got, want));
    end
  endtask

  // Advance one sensor's receiver by one event and build its report
  function automatic beacon_report_t receive_event(input logic kind,
                                                   input logic [SENSOR_W-1:0] sid,
                                                   input logic smp);
    beacon_report_t     rep;
    entry_t             ent;
    logic [COUNT_W-1:0] cnt;
    logic [3:0]         idx;
    logic [2:0]         want;
    logic [2:0]         miss;
    rep = '{sensor: sid, flags: 3'b000, next_wait: WAIT_POLL, restart: 1'b0};
    if (int'(sid) < SENSOR_COUNT) begin
      ent = sensor_state[sid];
      if (kind == REQ_WATCHDOG) begin
        // Clear flags, keep frame progress
        ent.flags      = '0;
        rep.next_wait  = WAIT_WDOG;
        rep.restart    = 1'b1;
      end else if (ent.phase == PH_DATA) begin
        cnt = ent.bit_count;
        if (cnt != COUNT_MAX) cnt++;
        ent.bit_count = cnt;
        idx  = cnt[3:0] - 4'd1;
        want = {shadow_cfg.pattern_three[idx], shadow_cfg.pattern_two[idx],
                shadow_cfg.pattern_one[idx]};
        miss = want ^ {3{smp}};
        ent.cand  = ent.cand & ~miss;
        ent.flags = ent.flags & ~miss;
        if (ent.cand != 3'b000) begin
          rep.next_wait = WAIT_BIT;
          rep.restart   = 1'b1;
          if (int'(cnt) < FRAME_BITS) ent.phase = PH_DATA;
          else ent.phase = PH_STOP;
        end else begin
          // No beacon left: abandon the frame
          ent.phase     = PH_IDLE;
          rep.next_wait = WAIT_QUIET;
          frames_dropped++;
        end
      end else if (ent.phase == PH_STOP) begin
        if (ent.bit_count != COUNT_MAX) ent.bit_count++;
        if (smp == shadow_cfg.stop_level) begin
          ent.flags   = ent.cand;
          rep.restart = 1'b1;
          if (ent.cand != 3'b000) frames_committed++;
        end else begin
          ent.flags     = '0;
          rep.next_wait = WAIT_QUIET;
        end
        ent.phase = PH_IDLE;
      end else if (smp == shadow_cfg.start_level) begin
        // Open a frame with every beacon as candidate
        ent.cand      = 3'b111;
        ent.bit_count = '0;
        ent.phase     = PH_DATA;
        rep.next_wait = WAIT_BIT;
        rep.restart   = 1'b1;
      end else begin
        ent.phase = PH_IDLE;
      end
      sensor_state[sid] = ent;
      rep.flags = ent.flags;
    end
    return rep;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      shadow_cfg = CFG_RESET;
      foreach (sensor_state[i]) sensor_state[i] = ENTRY_RESET;
      reports_due.delete();
    end else begin
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_ONE:   shadow_cfg.pattern_one   = cfg_data;
          REG_PATTERN_TWO:   shadow_cfg.pattern_two   = cfg_data;
          REG_PATTERN_THREE: shadow_cfg.pattern_three = cfg_data;
          REG_START_LEVEL:   shadow_cfg.start_level   = cfg_data[0];
          REG_STOP_LEVEL:    shadow_cfg.stop_level    = cfg_data[0];
          default: ;
        endcase
      end
      // Compare each result transfer with the oldest prediction
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          report_error($sformatf("result for sensor %0d with nothing pending",
                                 out_sensor));
        end else begin
          due = reports_due.pop_front();
          reports_checked++;
          check_field("out_sensor", 4'(out_sensor), 4'(due.sensor));
          check_field("match_one", 4'(out_match_one), 4'(due.flags[0]));
          check_field("match_two", 4'(out_match_two), 4'(due.flags[1]));
          check_field("match_three", 4'(out_match_three), 4'(due.flags[2]));
          check_field("next_wait", 4'(out_next_wait), 4'(due.next_wait));
          check_field("watchdog_restart", 4'(out_watchdog_restart), 4'(due.restart));
        end
      end
      // Predict on each event transfer
      if (in_valid && !in_stall) begin
        reports_due.push_back(receive_event(in_req_type, in_sensor_id, in_sample));
      end
    end
    reports_pending = reports_due.size();
  end

endmodule

// ===== verif/beacon_frame_matcher_tb.sv =====
// Testbench top for the beacon frame matcher: clock, reset, event and register
// stimulus, result stalls, timeout and verdict. Depends on bfm_pkg,
// beacon_frame_matcher and beacon_frame_checker.
module beacon_frame_matcher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bfm_pkg::*;

  localparam int FRAME_BITS    = 8;
  localparam int SENSOR_COUNT  = 16;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 205;
  localparam int IDLE_LIMIT    = 2000;

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic                 in_req_type  = REQ_SAMPLE;
  logic [SENSOR_W-1:0]  in_sensor_id = '0;
  logic                 in_sample    = 1'b0;
  logic                 out_stall    = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [PATTERN_W-1:0] cfg_data     = '0;

  logic                 in_stall;
  logic                 out_valid;
  logic [SENSOR_W-1:0]  out_sensor;
  logic                 out_match_one;
  logic                 out_match_two;
  logic                 out_match_three;
  logic [1:0]           out_next_wait;
  logic                 out_watchdog_restart;
  logic                 cfg_ready;

  int error_count;
  int reports_pending;
  int reports_checked;
  int frames_committed;
  int frames_dropped;

  // Stimulus-side view of the configuration and of each sensor's frame
  logic [PATTERN_W-1:0] pattern_set [3];
  logic                 start_lvl;
  logic                 stop_lvl;
  int                   frame_pos [SENSOR_COUNT];
  int                   frame_target [SENSOR_COUNT];

  int burst_left    = 0;
  int events_sent   = 0;
  int watchdog_sent = 0;
  int settings_used = 0;
  int idle_cycles   = 0;
  int stall_mode    = 0;
  int mode_left     = 0;
  int run_left      = 0;

  beacon_frame_matcher #(
    .FRAME_BITS   (FRAME_BITS),
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_top (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_sensor_id         (in_sensor_id),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_sensor           (out_sensor),
    .out_match_one        (out_match_one),
    .out_match_two        (out_match_two),
    .out_match_three      (out_match_three),
    .out_next_wait        (out_next_wait),
    .out_watchdog_restart (out_watchdog_restart),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  beacon_frame_checker #(
    .FRAME_BITS   (FRAME_BITS),
    .SENSOR_COUNT (SENSOR_COUNT)
  ) u_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_req_type          (in_req_type),
    .in_sensor_id         (in_sensor_id),
    .in_sample            (in_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_sensor           (out_sensor),
    .out_match_one        (out_match_one),
    .out_match_two        (out_match_two),
    .out_match_three      (out_match_three),
    .out_next_wait        (out_next_wait),
    .out_watchdog_restart (out_watchdog_restart),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .error_count          (error_count),
    .reports_pending      (reports_pending),
    .reports_checked      (reports_checked),
    .frames_committed     (frames_committed),
    .frames_dropped       (frames_dropped)
  );

  always #5 clk = ~clk;

  // Stall results: free stretches, random stalls, or long stall runs
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          out_stall <= !out_stall;
          run_left = out_stall ? $urandom_range(1, 8) : $urandom_range(1, 24);
        end else begin
          run_left--;
        end
      end
    endcase
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // One event transfer; open a gap first when the current burst is spent
  task automatic send_event(input logic kind, input logic [SENSOR_W-1:0] sid,
                            input logic smp);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 16);
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    in_req_type  <= kind;
    in_sensor_id <= sid;
    in_sample    <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
    events_sent++;
    if (kind == REQ_WATCHDOG) watchdog_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [PATTERN_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic program_config(input logic [PATTERN_W-1:0] p1,
                                input logic [PATTERN_W-1:0] p2,
                                input logic [PATTERN_W-1:0] p3,
                                input logic start_l, input logic stop_l);
    write_reg(REG_PATTERN_ONE, p1);
    write_reg(REG_PATTERN_TWO, p2);
    write_reg(REG_PATTERN_THREE, p3);
    write_reg(REG_START_LEVEL, {15'b0, start_l});
    write_reg(REG_STOP_LEVEL, {15'b0, stop_l});
    @(negedge clk) cfg_valid <= 1'b0;
    pattern_set[0] = p1;
    pattern_set[1] = p2;
    pattern_set[2] = p3;
    start_lvl      = start_l;
    stop_lvl       = stop_l;
    settings_used++;
  endtask

  // Hold off events until every outstanding result has been transferred
  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    burst_left = 0;
    while (reports_pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Start bit, the frame's data bits LSB first, then the given stop bit
  task automatic send_frame(input logic [SENSOR_W-1:0] sid,
                            input logic [PATTERN_W-1:0] bits, input logic stop_bit);
    send_event(REQ_SAMPLE, sid, start_lvl);
    for (int i = 0; i < FRAME_BITS; i++) send_event(REQ_SAMPLE, sid, bits[i]);
    send_event(REQ_SAMPLE, sid, stop_bit);
  endtask

  // Mostly well-formed frames per sensor, with watchdogs, noise and bad bits
  task automatic random_event();
    int                  pick;
    int                  pos;
    logic [SENSOR_W-1:0] sid;
    logic                bitv;
    pick = $urandom_range(0, 99);
    sid  = SENSOR_W'($urandom_range(0, SENSOR_COUNT - 1));
    if (pick < 5) begin
      send_event(REQ_WATCHDOG, sid, 1'($urandom));
    end else if (pick < 10) begin
      send_event(REQ_SAMPLE, sid, 1'($urandom));
    end else begin
      pos = frame_pos[sid];
      if (pos == 0) begin
        bitv = ($urandom_range(0, 9) != 0) ? start_lvl : !start_lvl;
        if (bitv == start_lvl) begin
          frame_pos[sid]    = 1;
          frame_target[sid] = ($urandom_range(0, 6) == 0) ? 3 : $urandom_range(0, 2);
        end
      end else if (pos <= FRAME_BITS) begin
        if (frame_target[sid] == 3) begin
          bitv = 1'($urandom);
        end else begin
          bitv = pattern_set[frame_target[sid]][pos - 1];
          if ($urandom_range(0, 29) == 0) bitv = !bitv;
        end
        frame_pos[sid] = pos + 1;
      end else begin
        bitv = ($urandom_range(0, 6) != 0) ? stop_lvl : !stop_lvl;
        frame_pos[sid] = 0;
      end
      send_event(REQ_SAMPLE, sid, bitv);
    end
  endtask

  initial begin
    logic [PATTERN_W-1:0] p1;
    logic [PATTERN_W-1:0] p2;
    logic [PATTERN_W-1:0] p3;
    foreach (frame_pos[i]) begin
      frame_pos[i]    = 0;
      frame_target[i] = 0;
    end
    repeat (12) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed: beacons two and three agree inside the frame, one differs
    program_config(16'h00A5, 16'h5AA4, 16'hC3A4, 1'b1, 1'b0);
    send_event(REQ_SAMPLE, 4'd0, 1'b0);       // idle, no start bit
    send_frame(4'd0, 16'h00A5, 1'b0);         // beacon one only, good stop
    send_event(REQ_SAMPLE, 4'd15, 1'b1);      // start
    send_event(REQ_SAMPLE, 4'd15, 1'b0);      // drop beacon one
    send_event(REQ_SAMPLE, 4'd15, 1'b1);      // drop the rest: abandon
    send_event(REQ_WATCHDOG, 4'd0, 1'b1);     // watchdog clears committed flags
    send_frame(4'd15, 16'h5AA4, 1'b1);        // wrong stop bit

    // Random phases, the extremes first
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      drain();
      case (ph)
        0: program_config(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
        1: program_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
        2: program_config(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
        default: begin
          p1 = 16'($urandom);
          p2 = $urandom_range(0, 1) ? p1 ^ (16'h1 << $urandom_range(0, FRAME_BITS - 1))
                                    : 16'($urandom);
          p3 = ($urandom_range(0, 2) == 0) ? p2 : 16'($urandom);
          program_config(p1, p2, p3, 1'($urandom), 1'($urandom));
        end
      endcase
      repeat (PHASE_ITEMS) random_event();
    end

    drain();
    repeat (5) @(negedge clk);
    $display("Covered %0d events (%0d watchdog expiries) under %0d register settings.",
             events_sent, watchdog_sent, settings_used);
    $display("%0d results checked; %0d frames committed a beacon, %0d abandoned.",
             reports_checked, frames_committed, frames_dropped);
    if (error_count == 0 && reports_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
